FILE: hw/rtl/byte_pattern_match_finder_top_defines.svh
// ----------------------------------------------------------------------------
// Byte pattern match finder: assertion macros
// Shared property shapes for the port checker.
// ----------------------------------------------------------------------------
`ifndef BYTE_PATTERN_MATCH_FINDER_TOP_DEFINES_SVH
`define BYTE_PATTERN_MATCH_FINDER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off during reset
`define BPM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bpm assertion failed");

// Next-cycle implication, sampled on the rising clock, off during reset
`define BPM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bpm assertion failed");

`endif

FILE: hw/rtl/bpm_pkg.sv
// ----------------------------------------------------------------------------
// Byte pattern match finder: shared package
// Field widths, configuration register indexes and inter-module structs.
// ----------------------------------------------------------------------------
package bpm_pkg;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 64;
  localparam int unsigned PAT_REGS    = 4;
  localparam int unsigned PAT_BYTES   = 32;
  localparam int unsigned PAT_W       = PAT_BYTES * 8;
  localparam int unsigned LEN_REG_W   = 6;
  localparam int unsigned COUNT_W     = 32;
  localparam int unsigned POS_OUT_W   = 32;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned OUT_TDATA_W = POS_OUT_W + COUNT_W;

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_PAT_0   = 3'd0,
    CFG_PAT_1   = 3'd1,
    CFG_PAT_2   = 3'd2,
    CFG_PAT_3   = 3'd3,
    CFG_PAT_LEN = 3'd4,
    CFG_OVERLAP = 3'd5
  } cfg_index_t;

  // Current configuration seen by the matcher
  typedef struct packed {
    logic [PAT_W-1:0]     pattern;
    logic [LEN_REG_W-1:0] pattern_length;
    logic                 overlap_en;
  } cfg_t;

  // Outcome of one byte, from the matcher to the output stage
  typedef struct packed {
    logic                 result;
    logic                 hit;
    logic                 done;
    logic [POS_OUT_W-1:0] position;
    logic [COUNT_W-1:0]   count;
  } result_t;

endpackage

FILE: hw/rtl/byte_pattern_match_finder_top.sv
// A result is shown on out_tvalid once its byte has passed the input register,
//   then the result register.
// Throughput: one byte per cycle unless a result waits on a stalled output.
// Bytes that give no result leave the input register even while out is stalled.
// Reset (rst_n low, synchronous) empties both registers, clears the search state
//   and sets the pattern to zero, length to one and overlap mode on.
// ----------------------------------------------------------------------------
// Byte pattern match finder: top level
// Stream search for a configured byte pattern: one result per match, and the last
// byte of each text always gives a closing result carrying the total count.
// ----------------------------------------------------------------------------
module byte_pattern_match_finder_top #(
  parameter int unsigned MAX_PATTERN = 32,
  parameter int unsigned INDEX_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [bpm_pkg::BYTE_W-1:0]          in_tdata,   // [7:0] text_byte
  input  logic                                in_tlast,   // last_byte
  // Result stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [bpm_pkg::OUT_TDATA_W-1:0]     out_tdata,  // [31:0] match_position,
                                                          // [63:32] match_count
  output logic                                out_tuser,  // match_found
  output logic                                out_tlast,  // stream_done
  // Configuration write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bpm_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [bpm_pkg::CFG_DATA_W-1:0]      cfg_data
);

  bpm_pkg::cfg_t    cfg;
  bpm_pkg::result_t res;

  logic                          in_vld_r;
  logic [bpm_pkg::BYTE_W-1:0]    in_byte_r;
  logic                          in_last_r;
  logic                          out_vld_r;
  logic [bpm_pkg::OUT_TDATA_W-1:0] out_data_r;
  logic                          out_found_r;
  logic                          out_done_r;
  logic                          advance;

  assign cfg_ready = 1'b1;

  bpm_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bpm_matcher #(
    .MAX_PATTERN (MAX_PATTERN),
    .INDEX_WIDTH (INDEX_WIDTH)
  ) u_match (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .text_byte (in_byte_r),
    .last_byte (in_last_r),
    .cfg       (cfg),
    .res       (res)
  );

  // Move the held byte on when its result has room or it gives none
  assign advance   = in_vld_r && (!out_vld_r || out_tready || !res.result);
  assign in_tready = !in_vld_r || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  // Result register: load on a result, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance && res.result) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.result) begin
      out_data_r  <= {res.count, res.position};
      out_found_r <= res.hit;
      out_done_r  <= res.done;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_found_r;
  assign out_tlast  = out_done_r;

endmodule

FILE: hw/rtl/bpm_cfg_regs.sv
// ----------------------------------------------------------------------------
// Byte pattern match finder: configuration registers
// Pattern bytes, pattern length and overlap mode, written by index.
// ----------------------------------------------------------------------------
module bpm_cfg_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  input  logic [bpm_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [bpm_pkg::CFG_DATA_W-1:0]      cfg_data,
  output bpm_pkg::cfg_t                       cfg
);

  logic [bpm_pkg::PAT_W-1:0]     pattern_r;
  logic [bpm_pkg::LEN_REG_W-1:0] length_r;
  logic                          overlap_r;

  // Write the addressed register; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_r <= '0;
      length_r  <= bpm_pkg::LEN_REG_W'(1);
      overlap_r <= 1'b1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        bpm_pkg::CFG_PAT_0:   pattern_r[0*bpm_pkg::CFG_DATA_W +: bpm_pkg::CFG_DATA_W] <= cfg_data;
        bpm_pkg::CFG_PAT_1:   pattern_r[1*bpm_pkg::CFG_DATA_W +: bpm_pkg::CFG_DATA_W] <= cfg_data;
        bpm_pkg::CFG_PAT_2:   pattern_r[2*bpm_pkg::CFG_DATA_W +: bpm_pkg::CFG_DATA_W] <= cfg_data;
        bpm_pkg::CFG_PAT_3:   pattern_r[3*bpm_pkg::CFG_DATA_W +: bpm_pkg::CFG_DATA_W] <= cfg_data;
        bpm_pkg::CFG_PAT_LEN: length_r  <= cfg_data[bpm_pkg::LEN_REG_W-1:0];
        bpm_pkg::CFG_OVERLAP: overlap_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign cfg.pattern        = pattern_r;
  assign cfg.pattern_length = length_r;
  assign cfg.overlap_en     = overlap_r;

endmodule

FILE: hw/rtl/bpm_matcher.sv
// ----------------------------------------------------------------------------
// Byte pattern match finder: window and compare
// Holds the byte window, fill count, position and match count, compares the
// shifted window with the pattern and updates the search state on each step.
// ----------------------------------------------------------------------------
module bpm_matcher #(
  parameter int unsigned MAX_PATTERN = 32,
  parameter int unsigned INDEX_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step,
  input  logic [bpm_pkg::BYTE_W-1:0]    text_byte,
  input  logic                          last_byte,
  input  bpm_pkg::cfg_t                 cfg,
  output bpm_pkg::result_t              res
);

  localparam int unsigned LW = $clog2(MAX_PATTERN + 1);
  localparam int unsigned IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int unsigned PW = (INDEX_WIDTH > bpm_pkg::POS_OUT_W) ?
                               INDEX_WIDTH : bpm_pkg::POS_OUT_W;

  logic [MAX_PATTERN-1:0][bpm_pkg::BYTE_W-1:0] window_r, window_nxt;
  logic [LW-1:0]                   fill_r, fill_inc, fill_nxt;
  logic [INDEX_WIDTH-1:0]          pos_r, pos_nxt;
  logic [bpm_pkg::COUNT_W-1:0]     count_r, count_nxt;
  logic [LW-1:0]                   len_used;
  logic                            bytes_eq;
  logic                            hit;
  logic [PW-1:0]                   start_full;

  // Shift the new byte in at entry 0
  always_comb begin
    window_nxt[0] = text_byte;
    for (int j = 1; j < MAX_PATTERN; j++) begin
      window_nxt[j] = window_r[j-1];
    end
  end

  // Clamp the pattern length into one to MAX_PATTERN
  always_comb begin
    priority if (cfg.pattern_length == '0) begin
      len_used = LW'(1);
    end else if (cfg.pattern_length > bpm_pkg::LEN_REG_W'(MAX_PATTERN)) begin
      len_used = LW'(MAX_PATTERN);
    end else begin
      len_used = LW'(cfg.pattern_length);
    end
  end

  assign fill_inc = (fill_r == LW'(MAX_PATTERN)) ? fill_r : fill_r + 1'b1;

  // Compare pattern byte k with the window entry len-1-k, for k below len
  always_comb begin
    logic [LW-1:0] idx;
    bytes_eq = 1'b1;
    for (int k = 0; k < MAX_PATTERN; k++) begin
      idx = len_used - 1'b1 - LW'(k);
      if (LW'(k) < len_used) begin
        if (window_nxt[idx[IW-1:0]] != cfg.pattern[k*bpm_pkg::BYTE_W +: bpm_pkg::BYTE_W]) begin
          bytes_eq = 1'b0;
        end
      end
    end
  end

  assign hit = (fill_inc >= len_used) && bytes_eq;

  // Start index of the occurrence ending at this byte
  assign start_full = PW'(pos_r) - PW'(len_used - 1'b1);

  // Saturating counters and fill update
  always_comb begin
    count_nxt = count_r;
    if (hit && (count_r != '1)) begin
      count_nxt = count_r + 1'b1;
    end
    pos_nxt = (pos_r == '1) ? pos_r : pos_r + 1'b1;
    fill_nxt = (hit && !cfg.overlap_en) ? '0 : fill_inc;
  end

  // Advance the search state; restart after the last byte of a text
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r  <= '0;
      pos_r   <= '0;
      count_r <= '0;
    end else if (step) begin
      if (last_byte) begin
        fill_r  <= '0;
        pos_r   <= '0;
        count_r <= '0;
      end else begin
        fill_r  <= fill_nxt;
        pos_r   <= pos_nxt;
        count_r <= count_nxt;
      end
    end
  end

  // Window contents only count below the fill level, so no reset
  always_ff @(posedge clk) begin
    if (step) begin
      window_r <= window_nxt;
    end
  end

  assign res.result   = hit || last_byte;
  assign res.hit      = hit;
  assign res.done     = last_byte;
  assign res.position = hit ? start_full[bpm_pkg::POS_OUT_W-1:0] : '0;
  assign res.count    = count_nxt;

endmodule

FILE: hw/rtl/bpm_checker.sv
// ----------------------------------------------------------------------------
// Byte pattern match finder: port checker
// Watches the top-level ports for result ordering and stall behaviour.
// ----------------------------------------------------------------------------
`include "byte_pattern_match_finder_top_defines.svh"

module bpm_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_tready,
  input logic                                out_tvalid,
  input logic                                out_tready,
  input logic [bpm_pkg::OUT_TDATA_W-1:0]     out_tdata,
  input logic                                out_tuser,
  input logic                                out_tlast
);

  logic                          out_stall;
  logic [bpm_pkg::POS_OUT_W-1:0] out_pos;

  assign out_stall = out_tvalid && !out_tready;
  assign out_pos   = out_tdata[bpm_pkg::POS_OUT_W-1:0];

  // A stalled result holds its data
  `BPM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, out_tvalid && $stable(out_tdata))

  // A result without a match can only be the closing one of a text
  `BPM_ASSERT_IMPL(a_nomatch_is_done, clk, rst_n, out_tvalid && !out_tuser, out_tlast)

  // A result without a match carries a zero start index
  `BPM_ASSERT_IMPL(a_nomatch_pos_zero, clk, rst_n, out_tvalid && !out_tuser, out_pos == '0)

  // With the result register empty the input side never stalls
  `BPM_ASSERT_IMPL(a_in_free, clk, rst_n, !out_tvalid, in_tready)

endmodule

bind byte_pattern_match_finder_top bpm_checker u_bpm_checker (.*);

FILE: dv/byte_pattern_match_finder_top_tb.sv
// ----------------------------------------------------------------------------
// Byte pattern match finder: top-level testbench
// Streams texts into the finder under a series of pattern settings and checks
// every result item against an in-bench predictor of the search.
// ----------------------------------------------------------------------------
module byte_pattern_match_finder_top_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WINDOW_BYTES   = 32;
  localparam int unsigned SETTLE_CYCLES  = 4;
  localparam int unsigned WATCHDOG_LIMIT = 400;
  localparam int unsigned RANDOM_PHASES  = 13;
  localparam int unsigned PHASE_BYTES    = 95;
  localparam int unsigned REPORT_CAP     = 50;

  typedef logic [7:0] text_t [$];
  typedef logic [7:0] pattern_bytes_t [WINDOW_BYTES];

  typedef struct packed {
    logic        found;
    logic [31:0] position;
    logic        done;
    logic [31:0] count;
  } match_result_t;

  // Clock, reset and block ports
  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [bpm_pkg::BYTE_W-1:0]      in_tdata = '0;    // [7:0] text_byte
  logic                            in_tlast = 1'b0;  // last_byte
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  // [31:0] match_position, [63:32] match_count
  logic [bpm_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                            out_tuser;        // match_found
  logic                            out_tlast;        // stream_done
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [bpm_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [bpm_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

  // Predictor copy of the registers and the search state
  logic [63:0] pattern_q [bpm_pkg::PAT_REGS];
  logic [5:0]  length_q;
  logic        overlap_q;
  logic [7:0]  window_q [WINDOW_BYTES];
  int unsigned fill_q;
  logic [31:0] byte_index_q;
  logic [31:0] found_q;

  match_result_t pending_results [$];

  // Run statistics
  int unsigned mismatch_count = 0;
  int unsigned results_checked = 0;
  int unsigned matches_seen = 0;
  int unsigned texts_sent = 0;
  int unsigned bytes_sent = 0;
  int unsigned settings_applied = 0;
  bit          no_idle = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  byte_pattern_match_finder_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  task automatic report_mismatch(input string msg);
    if (mismatch_count < REPORT_CAP) begin
      $display("%0t ns mismatch: %s", $realtime, msg);
    end
    mismatch_count++;
  endtask

  function automatic void clear_search_model();
    for (int i = 0; i < WINDOW_BYTES; i++) window_q[i] = 8'h00;
    fill_q = 0;
    byte_index_q = '0;
    found_q = '0;
  endfunction

  // Shift one text byte into the window and work out the result item, if any
  function automatic bit scan_text_byte(input logic [7:0] text_byte, input logic last_byte,
                                        output match_result_t res);
    int unsigned span;
    logic [31:0] start_index;
    bit hit;
    span = (length_q == 0) ? 1 : ((length_q > WINDOW_BYTES) ? WINDOW_BYTES : length_q);
    start_index = byte_index_q;
    for (int i = WINDOW_BYTES - 1; i > 0; i--) window_q[i] = window_q[i-1];
    window_q[0] = text_byte;
    if (fill_q < WINDOW_BYTES) fill_q++;
    // oldest byte of the candidate sits at window entry span-1
    hit = (fill_q >= span);
    for (int k = 0; k < span; k++) begin
      if (window_q[span-1-k] != pattern_q[k/8][(k%8)*8 +: 8]) hit = 1'b0;
    end
    if (hit) begin
      if (found_q != '1) found_q++;
      if (!overlap_q) fill_q = 0;
    end
    if (byte_index_q != '1) byte_index_q++;
    res.found    = hit;
    res.position = hit ? start_index - 32'(span - 1) : '0;
    res.done     = last_byte;
    res.count    = found_q;
    if (last_byte) clear_search_model();
    return hit || last_byte;
  endfunction

  // Check result items, track register writes and predict from accepted items
  always @(posedge clk) begin
    match_result_t seen;
    match_result_t want;
    if (!rst_n) begin
      for (int r = 0; r < bpm_pkg::PAT_REGS; r++) pattern_q[r] = '0;
      length_q = 6'd1;
      overlap_q = 1'b1;
      clear_search_model();
      pending_results.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        seen.found    = out_tuser;
        seen.position = out_tdata[31:0];
        seen.done     = out_tlast;
        seen.count    = out_tdata[63:32];
        results_checked++;
        if (seen.found) matches_seen++;
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result item %0d/%0d/%0d/%0d", seen.found,
                                    seen.position, seen.done, seen.count));
        end else begin
          want = pending_results.pop_front();
          if (seen.found !== want.found)
            report_mismatch($sformatf("match_found got %0b want %0b", seen.found, want.found));
          if (seen.position !== want.position)
            report_mismatch($sformatf("match_position got %0d want %0d", seen.position,
                                      want.position));
          if (seen.done !== want.done)
            report_mismatch($sformatf("stream_done got %0b want %0b", seen.done, want.done));
          if (seen.count !== want.count)
            report_mismatch($sformatf("match_count got %0d want %0d", seen.count, want.count));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          bpm_pkg::CFG_PAT_0:   pattern_q[0] = cfg_data;
          bpm_pkg::CFG_PAT_1:   pattern_q[1] = cfg_data;
          bpm_pkg::CFG_PAT_2:   pattern_q[2] = cfg_data;
          bpm_pkg::CFG_PAT_3:   pattern_q[3] = cfg_data;
          bpm_pkg::CFG_PAT_LEN: length_q = cfg_data[5:0];
          bpm_pkg::CFG_OVERLAP: overlap_q = cfg_data[0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        if (scan_text_byte(in_tdata, in_tlast, want)) pending_results.push_back(want);
      end
    end
  end

  // Result receiver: stall a random number of cycles before each item
  initial begin
    int unsigned stall;
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
    end
  end

  // Watchdog: give up after a long stretch with no handshake on any channel
  initial begin
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("%0t ns timeout: no handshake for %0d cycles", $realtime, WATCHDOG_LIMIT);
    $display("byte_pattern_match_finder_top_tb NOT OK");
    $finish;
  end

  // Offer one text byte after a random gap; valid stays high for a back-to-back item
  task automatic send_text_byte(input logic [7:0] text_byte, input logic last_byte);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= text_byte;
    in_tlast  <= last_byte;
    do @(posedge clk); while (!in_tready);
    bytes_sent++;
  endtask

  task automatic send_text(input text_t text);
    for (int i = 0; i < text.size(); i++) send_text_byte(text[i], i == text.size() - 1);
    texts_sent++;
  endtask

  // Drop valid, drain every expected result, then allow in-flight bytes to leave
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input bpm_pkg::cfg_index_t idx, input logic [63:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic apply_settings(input pattern_bytes_t pat, input logic [63:0] length_word,
                                input logic [63:0] overlap_word);
    logic [63:0] words [bpm_pkg::PAT_REGS];
    for (int k = 0; k < WINDOW_BYTES; k++) words[k/8][(k%8)*8 +: 8] = pat[k];
    write_register(bpm_pkg::CFG_PAT_0, words[0]);
    write_register(bpm_pkg::CFG_PAT_1, words[1]);
    write_register(bpm_pkg::CFG_PAT_2, words[2]);
    write_register(bpm_pkg::CFG_PAT_3, words[3]);
    write_register(bpm_pkg::CFG_PAT_LEN, length_word);
    write_register(bpm_pkg::CFG_OVERLAP, overlap_word);
    cfg_valid <= 1'b0;
    settings_applied++;
  endtask

  // Reset settings: zero pattern of length one, so every zero byte matches
  task automatic test_reset_defaults();
    send_text('{8'h00, 8'hFF, 8'h00});
  endtask

  // Overlapping matches with overlap on, resumption after match end with it off;
  // the text ends on a completed match only in the overlap-on run
  task automatic test_overlap_modes();
    pattern_bytes_t pat;
    pat = '{default: 8'h00};
    pat[0] = 8'hFF;
    pat[2] = 8'hFF;
    settle();
    apply_settings(pat, 64'd3, 64'd1);
    send_text('{8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF});
    settle();
    apply_settings(pat, 64'd3, 64'd0);
    send_text('{8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF});
  endtask

  // Length field of zero acts as one; final byte without a match still reports
  task automatic test_zero_length();
    pattern_bytes_t pat;
    pat = '{default: 8'h3C};
    pat[0] = 8'hA5;
    settle();
    apply_settings(pat, 64'd0, 64'd1);
    send_text('{8'hA5, 8'h5A});
  endtask

  // Phases of random settings, each streaming texts built from the pattern,
  // spoiled copies of it, bytes of its alphabet and random noise
  task automatic test_random_texts();
    pattern_bytes_t pat;
    text_t text;
    logic [7:0] sym_a;
    logic [7:0] sym_b;
    logic [5:0] len_field;
    logic overlap;
    logic [63:0] len_word;
    logic [63:0] overlap_word;
    int unsigned span;
    int unsigned phase_bytes;
    int unsigned n_target;
    int unsigned spoil;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      no_idle = ($urandom_range(0, 3) == 0);
      sym_a = 8'($urandom);
      sym_b = ($urandom_range(0, 3) == 0) ? sym_a : 8'($urandom);
      len_field = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                              : 6'($urandom_range(1, 4));
      overlap = 1'($urandom);
      // pin the extremes in the opening phases
      case (phase)
        0: begin sym_a = 8'h00; sym_b = 8'h00; len_field = 6'd32; overlap = 1'b1; end
        1: begin sym_a = 8'hFF; sym_b = 8'hFF; len_field = 6'd63; overlap = 1'b0; end
        2: len_field = 6'd0;
        3: len_field = 6'd33;
        4: begin len_field = 6'd1; overlap = 1'b0; end
        default: ;
      endcase
      for (int k = 0; k < WINDOW_BYTES; k++) pat[k] = $urandom_range(0, 1) ? sym_a : sym_b;
      // upper bits of the length and mode words must be ignored
      len_word = {$urandom, $urandom};
      len_word[5:0] = len_field;
      overlap_word = {$urandom, $urandom};
      overlap_word[0] = overlap;
      span = (len_field == 0) ? 1 : ((len_field > WINDOW_BYTES) ? WINDOW_BYTES : len_field);
      settle();
      apply_settings(pat, len_word, overlap_word);
      phase_bytes = 0;
      while (phase_bytes < PHASE_BYTES) begin
        text.delete();
        n_target = $urandom_range(1, 2 * span + 12);
        while (text.size() < n_target) begin
          case ($urandom_range(0, 9))
            0, 1: begin
              spoil = ($urandom_range(0, 3) == 0) ? $urandom_range(0, span - 1) : span;
              for (int k = 0; k < span; k++) text.push_back(k == spoil ? ~pat[k] : pat[k]);
            end
            2: text.push_back(8'($urandom));
            default: text.push_back($urandom_range(0, 1) ? sym_a : sym_b);
          endcase
        end
        send_text(text);
        phase_bytes += text.size();
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_overlap_modes();
    test_zero_length();
    test_random_texts();
    settle();
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d expected results never arrived", pending_results.size()));
    $display("covered %0d texts, %0d bytes, under %0d register settings", texts_sent, bytes_sent,
             settings_applied);
    $display("checked %0d result items, %0d of them matches, %0d mismatches", results_checked,
             matches_seen, mismatch_count);
    if (mismatch_count == 0) begin
      $display("byte_pattern_match_finder_top_tb OK");
    end else begin
      $display("byte_pattern_match_finder_top_tb NOT OK");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/bpm_pkg.sv
hw/rtl/bpm_cfg_regs.sv
hw/rtl/bpm_matcher.sv
hw/rtl/byte_pattern_match_finder_top.sv
hw/rtl/bpm_checker.sv
dv/byte_pattern_match_finder_top_tb.sv
